// ----- rtl/animation_easing_progress_defines.svh -----
// Assertion macros used by the easing progress top level
`ifndef ANIMATION_EASING_PROGRESS_DEFINES_SVH
`define ANIMATION_EASING_PROGRESS_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define AEP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define AEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/aep_pkg.sv -----
// Package: payload words and curve codes for the easing progress block
package aep_pkg;
  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [31:0] duration_ms;
    logic [2:0]  curve;
  } aep_in_t;

  typedef struct packed {
    logic [16:0] progress;
    logic        done_res;
  } aep_out_t;

  localparam logic [2:0] CURVE_LINEAR = 3'd0;
  localparam logic [2:0] CURVE_SLOW   = 3'd1;
  localparam logic [2:0] CURVE_SPEED  = 3'd2;
  localparam logic [2:0] CURVE_STEP   = 3'd3;
  localparam logic [2:0] CURVE_SMOOTH = 3'd4;
endpackage

// ----- rtl/animation_easing_progress.sv -----
// Top level: pipelined easing progress evaluator
// Usage: one word per cycle enters on in (in_valid/in_stall) while in_stall
// is low, carrying elapsed time, duration and a curve code; one result word
// leaves on out (out_valid/out_stall) with eased Q1.FRAC_BITS progress and a
// done flag. Throughput is one word per cycle while out_stall does not hold
// the pipeline. A word passes the time divider in ceil(FRAC_BITS/4) stages, then
// three product stages, then the smooth curve divider in ceil((FRAC_BITS+1)/4)
// stages, then the output register. The pipeline depth is set by the two
// restoring dividers, at most four quotient bits per stage.
// When out_stall is high with a result waiting, the whole pipeline holds;
// a word is taken on in only while the pipeline may advance, so nothing is
// lost or repeated. Reset clears all valid bits; no result word is
// presented until a new input word has passed through.
module animation_easing_progress
  import aep_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  aep_in_t  in,
  output logic     out_valid,
  input  logic     out_stall,
  output aep_out_t out
);
`include "animation_easing_progress_defines.svh"

  localparam int TB  = (TIME_BITS > 32) ? 32 : TIME_BITS;
  localparam int PW  = FRAC_BITS + 1;       // progress width, holds ONE
  localparam int WW  = FRAC_BITS + 4;       // working width for 3*ONE etc
  localparam int DW  = 2 * WW + 2;          // smooth divider width
  localparam logic [WW-1:0] ONE  = WW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] HALF = WW'(1) << (FRAC_BITS - 1);

  // whole pipeline advances unless a result is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // tag carried through the time divider: curve, done
  logic [TB-1:0] el, du;
  logic          done_in;
  assign el      = in.elapsed_ms[TB-1:0];
  assign du      = in.duration_ms[TB-1:0];
  assign done_in = el >= du;

  logic          d1_v;
  logic [FRAC_BITS-1:0] d1_q;
  logic [3:0]    d1_t;

  aep_divider #(.NBITS(TB + 1), .QBITS(FRAC_BITS), .SBITS(4), .TBITS(4)) u_tdiv (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(in_valid && adv),
    .num(done_in ? '0 : {1'b0, el}),
    .den({1'b0, du}),
    .tag_in({in.curve, done_in}),
    .out_valid(d1_v), .quot(d1_q), .tag_out(d1_t)
  );

  // stage A: linear progress, first products
  logic [WW-1:0] p_c, base_c;
  assign p_c    = d1_t[0] ? ONE : WW'(d1_q);
  assign base_c = (d1_t[3:1] == CURVE_SLOW) ? ONE - p_c : p_c;

  logic          a_v, a_done;
  logic [2:0]    a_cv;
  logic [WW-1:0] a_p, a_b, a_sq, a_n, a_d;
  logic          a_rise;

  logic [2*WW-1:0] sq_full;
  logic [WW-1:0]   five_c, two_c;
  assign sq_full = base_c * base_c + (2*WW)'(HALF);
  assign five_c  = WW'(5) * p_c;
  assign two_c   = ONE << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= d1_v;
    end
    if (adv) begin
      a_done <= d1_t[0];
      a_cv   <= d1_t[3:1];
      a_p    <= p_c;
      a_b    <= base_c;
      a_sq   <= WW'(sq_full >> FRAC_BITS);
      a_rise <= five_c > two_c;
      a_n    <= (five_c > two_c) ? five_c - two_c : two_c - five_c;
      a_d    <= p_c + two_c;
    end
  end

  // stage B: second product, smooth terms squared
  logic [WW-1:0]   mul2_c;
  logic [2*WW-1:0] pr2_full;
  assign mul2_c   = (a_cv == CURVE_STEP) ? (ONE + (ONE << 1)) - (a_p << 1) : a_b;
  assign pr2_full = a_sq * mul2_c + (2*WW)'(HALF);

  logic          b_v, b_done, b_rise, b_sat;
  logic [2:0]    b_cv;
  logic [WW-1:0] b_p, b_pr;
  logic [2*WW-1:0] b_nd, b_dd, b_nn;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
    if (adv) begin
      b_done <= a_done;
      b_cv   <= a_cv;
      b_p    <= a_p;
      b_pr   <= WW'(pr2_full >> FRAC_BITS);
      b_rise <= a_rise;
      b_sat  <= a_n >= a_d;
      b_nd   <= a_n * a_d;
      b_dd   <= a_d * a_d;
      b_nn   <= a_n * a_n;
    end
  end

  // stage C: select curve value, form smooth divider operands
  logic [WW-1:0] v_c;
  always_comb begin
    unique case (b_cv)
      CURVE_SLOW:  v_c = ONE - b_pr;
      CURVE_SPEED: v_c = b_pr;
      CURVE_STEP:  v_c = (b_pr > ONE) ? ONE : b_pr;
      default:     v_c = b_p;
    endcase
  end

  logic          c_v;
  logic [DW-1:0] c_num, c_den;
  logic [WW+3:0] c_tag;   // value, done, smooth, rise, sat

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
    if (adv) begin
      c_num <= b_sat ? '0 : DW'(b_nd);
      c_den <= DW'(b_dd) + DW'(b_nn);
      c_tag <= {v_c, b_done, b_cv == CURVE_SMOOTH, b_rise, b_sat};
    end
  end

  logic          e_v;
  logic [FRAC_BITS:0] e_q;
  logic [WW+3:0] e_t;

  aep_divider #(.NBITS(DW), .QBITS(FRAC_BITS + 1), .SBITS(4), .TBITS(WW + 4)) u_sdiv (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(c_v), .num(c_num), .den(c_den), .tag_in(c_tag),
    .out_valid(e_v), .quot(e_q), .tag_out(e_t)
  );

  // output stage: finish smooth curve rounding and register the word
  logic [WW-1:0] m_c, res_c;
  assign m_c = WW'((e_q >> 1) + (FRAC_BITS + 1)'(e_q[0]));
  always_comb begin
    if (!e_t[2]) begin
      res_c = e_t[WW+3:4];
    end else if (e_t[0]) begin
      res_c = e_t[1] ? ONE : '0;
    end else begin
      res_c = e_t[1] ? HALF + m_c : HALF - m_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_v;
    end
    if (adv) begin
      out.progress <= 17'(res_c);
      out.done_res <= e_t[3];
    end
  end

  // checks
  `AEP_ASSERT_IMP(a_stall_blocks_in, out_valid && out_stall, in_stall)
  `AEP_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `AEP_ASSERT_IMP(a_prog_range, out_valid, 21'(out.progress) <= 21'(ONE) || FRAC_BITS > 16)
endmodule

// ----- rtl/aep_divider.sv -----
// Pipelined restoring fraction divider: q = floor(num*2^QBITS/den), num < den
module aep_divider #(
  parameter int NBITS = 32,
  parameter int QBITS = 16,
  parameter int SBITS = 4,
  parameter int TBITS = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [NBITS-1:0] num,
  input  logic [NBITS-1:0] den,
  input  logic [TBITS-1:0] tag_in,
  output logic             out_valid,
  output logic [QBITS-1:0] quot,
  output logic [TBITS-1:0] tag_out
);
  // one quotient bit per step, a register stage every SBITS steps
  localparam int NST = (QBITS + SBITS - 1) / SBITS;

  logic [NBITS-1:0] r_q [NST+1];
  logic [NBITS-1:0] d_q [NST+1];
  logic [QBITS-1:0] q_q [NST+1];
  logic [TBITS-1:0] t_q [NST+1];
  logic             v_q [NST+1];

  always_comb begin
    r_q[0] = num;
    d_q[0] = den;
    q_q[0] = '0;
    t_q[0] = tag_in;
    v_q[0] = in_valid;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [NBITS-1:0] rn;
    logic [QBITS-1:0] qn;
    logic [NBITS-1:0] r_reg, d_reg;
    logic [QBITS-1:0] q_reg;
    logic [TBITS-1:0] t_reg;
    logic             v_reg;

    // up to SBITS dependent compare-subtract steps
    always_comb begin
      logic [NBITS:0] r2;
      r2 = '0;
      rn = r_q[s];
      qn = q_q[s];
      for (int k = 0; k < SBITS; k++) begin
        if (s * SBITS + k < QBITS) begin
          r2 = {rn, 1'b0};
          qn = {qn[QBITS-2:0], 1'b0};
          if (r2 >= {1'b0, d_q[s]}) begin
            r2 = r2 - {1'b0, d_q[s]};
            qn[0] = 1'b1;
          end
          rn = r2[NBITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_reg <= 1'b0;
      end else if (adv) begin
        v_reg <= v_q[s];
      end
      if (adv) begin
        r_reg <= rn;
        d_reg <= d_q[s];
        q_reg <= qn;
        t_reg <= t_q[s];
      end
    end

    always_comb begin
      r_q[s+1] = r_reg;
      d_q[s+1] = d_reg;
      q_q[s+1] = q_reg;
      t_q[s+1] = t_reg;
      v_q[s+1] = v_reg;
    end
  end

  assign out_valid = v_q[NST];
  assign quot      = q_q[NST];
  assign tag_out   = t_q[NST];
endmodule
